// File: rtl/core/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants and types of the 2x2 box downsampler: line store geometry,
// counter widths, configuration register indexes and the stage tag.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned PIXEL_BITS = 8;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned SUM_W      = PIXEL_BITS + 1;
  localparam int unsigned QUAD_W     = PIXEL_BITS + 2;
  localparam int unsigned CNT_W      = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] WIDTH_MIN  = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MIN = CFG_W'(2);
  localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(4096);
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic             row_end;
    logic             frame_end;
    logic [SUM_W-1:0] pair_sum;
  } bds_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/bds_ram.sv
// ----------------------------------------------------------------------------
// bds_ram
// Generic simple dual-port RAM: one write port, one read port with enable and
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/bds_scan.sv
// ----------------------------------------------------------------------------
// bds_scan
// Frame geometry registers and raster position tracking. Builds horizontal
// pair sums, writes them to the line store on even rows and issues line store
// reads with the block tag on odd rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_scan
  import bds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  accept,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic                  mem_we,
  output logic [LINE_AW-1:0]    mem_waddr,
  output logic [SUM_W-1:0]      mem_wdata,
  output logic                  mem_re,
  output logic [LINE_AW-1:0]    mem_raddr,
  output bds_tag_t              tag
);

  logic [CFG_W-1:0]      width_r, width_nxt;
  logic [CFG_W-1:0]      height_r, height_nxt;
  logic [CNT_W-1:0]      col_r, col_nxt;
  logic [CNT_W-1:0]      row_r, row_nxt;
  logic [PIXEL_BITS-1:0] left_r, left_nxt;
  logic [CFG_W-1:0]      col_inc;
  logic [CFG_W-1:0]      row_inc;
  logic                  col_last;
  logic                  row_last;
  logic                  restart;

  assign col_inc  = {1'b0, col_r} + CFG_W'(1);
  assign row_inc  = {1'b0, row_r} + CFG_W'(1);
  assign col_last = col_inc >= width_r;
  assign row_last = row_inc >= height_r;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_valid) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        restart = 1'b1;
        priority if (cfg_data < WIDTH_MIN) begin
          width_nxt = WIDTH_MIN;
        end else if (cfg_data > WIDTH_MAX) begin
          width_nxt = WIDTH_MAX;
        end else begin
          width_nxt = cfg_data;
        end
      end else if (cfg_index == CFG_FRAME_HEIGHT) begin
        restart = 1'b1;
        priority if (cfg_data < HEIGHT_MIN) begin
          height_nxt = HEIGHT_MIN;
        end else if (cfg_data > HEIGHT_MAX) begin
          height_nxt = HEIGHT_MAX;
        end else begin
          height_nxt = cfg_data;
        end
      end
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = '0;
    end else if (accept) begin
      if (!col_r[0]) begin
        left_nxt = pixel;
      end
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
    end
  end

  // even rows store pair sums, odd rows fetch them
  assign mem_we    = accept & col_r[0] & ~row_r[0];
  assign mem_re    = accept & col_r[0] & row_r[0];
  assign mem_waddr = col_r[CNT_W-1:1];
  assign mem_raddr = col_r[CNT_W-1:1];
  assign mem_wdata = {1'b0, left_r} + {1'b0, pixel};

  assign tag.pair_sum  = mem_wdata;
  assign tag.row_end   = col_inc == {width_r[CFG_W-1:1], 1'b0};
  assign tag.frame_end = tag.row_end & (row_inc == {height_r[CFG_W-1:1], 1'b0});

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < width_r)
    else $error("column position beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < height_r)
    else $error("row position beyond frame height");

  a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("line store written and read by one pixel");

endmodule

`default_nettype wire

// File: rtl/core/bds_avg.sv
// ----------------------------------------------------------------------------
// bds_avg
// Block stage and output register: adds the stored pair sum from the line
// store to the current pair sum, divides by four and holds the result until
// the downstream transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_avg
  import bds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_issue,
  input  bds_tag_t              tag,
  input  logic [SUM_W-1:0]      rd_data,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_pixel,
  output logic                  out_row_end,
  output logic                  out_frame_end
);

  logic                  blk_valid_r, blk_valid_nxt;
  bds_tag_t              blk_tag_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [PIXEL_BITS-1:0] pixel_r;
  logic                  row_end_r;
  logic                  frame_end_r;
  logic                  blk_adv;
  logic [QUAD_W-1:0]     quad_sum;

  assign blk_adv  = blk_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~blk_valid_r | blk_adv;
  assign quad_sum = {1'b0, rd_data} + {1'b0, blk_tag_r.pair_sum};

  always_comb begin
    blk_valid_nxt = blk_valid_r;
    if (rd_issue) begin
      blk_valid_nxt = 1'b1;
    end else if (blk_adv) begin
      blk_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (blk_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      blk_tag_r <= tag;
    end
    if (blk_adv) begin
      pixel_r     <= quad_sum[QUAD_W-1:2];
      row_end_r   <= blk_tag_r.row_end;
      frame_end_r <= blk_tag_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = pixel_r;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

  a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |-> in_ready)
    else $error("line store read issued while block stage is full");

  a_frame_end_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_end_r |-> row_end_r)
    else $error("end of frame without end of row");

  a_block_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    blk_adv |=> out_valid_r)
    else $error("block result lost on its way to the output register");

endmodule

`default_nettype wire

// File: rtl/core/box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-average image downscaler for grayscale raster frames.
// ----------------------------------------------------------------------------
// Takes one pixel per clock with no gaps needed, and gives one output pixel
// for each 2x2 block, the floor of its mean. The line store is read at the
// transfer of the block's bottom-right pixel; the read data and block tag are
// registered in the block stage, and the sum enters the output register once
// that register is free. in_tready drops only while a finished block waits
// behind a stalled output. The line store is a 2048 x 9 RAM with one
// write and one read port; pair sums of even rows go in, odd rows read them
// back, so no read ever meets a write to the same entry. It needs no clearing
// pass after reset. An odd last column or row is consumed without output.
// A write to either geometry register restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2
  import bds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIXEL_BITS-1:0] in_tdata,   // [7:0] pixel_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIXEL_BITS-1:0] out_tdata,  // [7:0] pixel_out
  output logic                  out_tlast,  // row_end
  output logic                  out_tuser   // [0] frame_end
);

  logic               accept;
  logic               mem_we;
  logic [LINE_AW-1:0] mem_waddr;
  logic [SUM_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [LINE_AW-1:0] mem_raddr;
  logic [SUM_W-1:0]   mem_rdata;
  bds_tag_t           tag;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid & in_tready;

  bds_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (in_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .tag       (tag)
  );

  bds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bds_avg u_avg (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_issue      (mem_re),
    .tag           (tag),
    .rd_data       (mem_rdata),
    .in_ready      (in_tready),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_pixel     (out_tdata),
    .out_row_end   (out_tlast),
    .out_frame_end (out_tuser)
  );

endmodule

`default_nettype wire
